>>> src/calu_pkg.sv
// Shared types and operation codes for the CPU arithmetic unit.
package calu_pkg;

    typedef enum logic [3:0] {
        OP_ADD8  = 4'd0,
        OP_ADC8  = 4'd1,
        OP_SUB8  = 4'd2,
        OP_SBC8  = 4'd3,
        OP_INC8  = 4'd4,
        OP_DEC8  = 4'd5,
        OP_INC16 = 4'd6,
        OP_DEC16 = 4'd7,
        OP_ADDHL = 4'd8,
        OP_ADDSP = 4'd9
    } op_t;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic        zero_in;
        logic        subtract_in;
        logic        half_in;
        logic        cflag_in;
    } req_t;

    typedef struct packed {
        logic [15:0] result;
        logic        zero_out;
        logic        subtract_out;
        logic        half_out;
        logic        cflag_out;
    } rsp_t;

endpackage

>>> src/calu_req_if.sv
// Request channel: valid/ready handshake carrying one operation word.
interface calu_req_if
    import calu_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/calu_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
interface calu_rsp_if
    import calu_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/calu_in_reg.sv
// Input register stage: captures one request word per cycle while in_ready is high.
module calu_in_reg
    import calu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output req_t out_data
);
    logic valid_reg;
    logic valid_next;
    req_t data_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

>>> src/calu_core.sv
// Combinational datapath: result and flags for one operation.
module calu_core
    import calu_pkg::*;
(
    input  req_t req,
    output rsp_t rsp
);
    logic [7:0]  a8;
    logic [7:0]  b8;
    logic        ci;
    logic [8:0]  sum9;
    logic [4:0]  lo5;
    logic [8:0]  dif9;
    logic [4:0]  dlo5;
    logic [16:0] sum17;
    logic [12:0] lo13;
    logic [15:0] ext;
    logic [7:0]  res8;

    always_comb
    begin
        a8    = req.operand_a[7:0];
        b8    = req.operand_b[7:0];
        // carry/borrow in only for ADC and SBC
        ci    = req.cflag_in &&
                (req.req_type == OP_ADC8 || req.req_type == OP_SBC8);
        sum9  = {1'b0, a8} + {1'b0, b8} + {8'd0, ci};
        lo5   = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, ci};
        dif9  = {1'b0, a8} - {1'b0, b8} - {8'd0, ci};
        dlo5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, ci};
        sum17 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
        lo13  = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
        ext   = {{8{b8[7]}}, b8};
        res8  = 8'd0;

        rsp.result       = req.operand_a;
        rsp.zero_out     = req.zero_in;
        rsp.subtract_out = req.subtract_in;
        rsp.half_out     = req.half_in;
        rsp.cflag_out    = req.cflag_in;

        unique case (req.req_type)
            OP_ADD8, OP_ADC8:
            begin
                res8             = sum9[7:0];
                rsp.result       = {8'd0, res8};
                rsp.zero_out     = (res8 == 8'd0);
                rsp.subtract_out = 1'b0;
                rsp.half_out     = lo5[4];
                rsp.cflag_out    = sum9[8];
            end
            OP_SUB8, OP_SBC8:
            begin
                res8             = dif9[7:0];
                rsp.result       = {8'd0, res8};
                rsp.zero_out     = (res8 == 8'd0);
                rsp.subtract_out = 1'b1;
                rsp.half_out     = dlo5[4];
                rsp.cflag_out    = dif9[8];
            end
            OP_INC8:
            begin
                res8             = a8 + 8'd1;
                rsp.result       = {8'd0, res8};
                rsp.zero_out     = (res8 == 8'd0);
                rsp.subtract_out = 1'b0;
                rsp.half_out     = (a8[3:0] == 4'hF);
            end
            OP_DEC8:
            begin
                res8             = a8 - 8'd1;
                rsp.result       = {8'd0, res8};
                rsp.zero_out     = (res8 == 8'd0);
                rsp.subtract_out = 1'b1;
                rsp.half_out     = (a8[3:0] == 4'h0);
            end
            OP_INC16:
            begin
                rsp.result = req.operand_a + 16'd1;
            end
            OP_DEC16:
            begin
                rsp.result = req.operand_a - 16'd1;
            end
            OP_ADDHL:
            begin
                rsp.result       = sum17[15:0];
                rsp.subtract_out = 1'b0;
                rsp.half_out     = lo13[12];
                rsp.cflag_out    = sum17[16];
            end
            OP_ADDSP:
            begin
                // H and C from the unsigned add of the low byte
                rsp.result       = req.operand_a + ext;
                rsp.zero_out     = 1'b0;
                rsp.subtract_out = 1'b0;
                rsp.half_out     = lo5[4];
                rsp.cflag_out    = sum9[8];
            end
            default:
            begin
                rsp.result = req.operand_a;
            end
        endcase
    end
endmodule

>>> src/calu_out_reg.sv
// Output register stage: holds one result word until taken.
module calu_out_reg
    import calu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  rsp_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);
    logic valid_reg;
    logic valid_next;
    rsp_t data_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

>>> src/cpu_arith_alu_8_16.sv
// Top level of the CPU arithmetic unit: input register, datapath, result register.
//
//   channel  dir  word   contents
//   req      in   req_t  op code, operands A and B, incoming Z N H C
//   rsp      out  rsp_t  16-bit result, new Z N H C
//
// One word per cycle sustained while rsp.ready stays high; an accepted req word passes
// through the input register and then the result register before rsp.valid rises.
// The datapath is a single pass of adders between the two register stages.
// Reset (rst_n low, async) empties both stages; no configuration.
// A stall on rsp backs up through the stages; req.ready drops only while both
// stages hold a word and rsp.ready is low.
module cpu_arith_alu_8_16
    import calu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    calu_req_if.sink   req,
    calu_rsp_if.source rsp
);
    logic s1_valid;
    logic s1_ready;
    req_t s1_data;
    rsp_t core_rsp;

    calu_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_data   (req.data),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    calu_core u_core (
        .req (s1_data),
        .rsp (core_rsp)
    );

    calu_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (core_rsp),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.data)
    );
endmodule
